// ----- rtl/lr_pkg.sv -----
// Shared types and constants of the line rasterizer.
`timescale 1ns / 1ps

package lr_pkg;

	localparam int COORD_BITS = 12;
	localparam int ADDR_BITS  = 33;
	localparam int COLOR_BITS = 32;
	localparam int FRAME_BITS = 13;
	localparam int PITCH_BITS = 15;
	localparam int BASE_BITS  = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	// Command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_PITCH    = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_BASE   = 2'd3;

	localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = 13'd640;
	localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;
	localparam logic [PITCH_BITS-1:0] ROW_PITCH_RESET    = 15'd2560;
	localparam logic [BASE_BITS-1:0]  FRAME_BASE_RESET   = 32'd0;

	typedef struct packed {
		logic                         command;
		logic signed [COORD_BITS-1:0] x_start;
		logic signed [COORD_BITS-1:0] y_start;
		logic signed [COORD_BITS-1:0] x_end;
		logic signed [COORD_BITS-1:0] y_end;
		logic [COLOR_BITS-1:0]        line_color;
	} lr_cmd_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pixel_x;
		logic signed [COORD_BITS-1:0] pixel_y;
		logic [ADDR_BITS-1:0]         pixel_address;
		logic [COLOR_BITS-1:0]        pixel_value;
		logic                         visible;
		logic                         last;
	} lr_pix_t;

endpackage

// ----- rtl/line_rasterizer.sv -----
// Bresenham line engine: command decode, line walk and pixel address stage.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------
//  cmd     | in        | cmd_valid / cmd_ready | lr_cmd_t (start or step)
//  pix     | out       | pix_valid / pix_ready | lr_pix_t (one pixel)
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request is taken per cycle while cmd_ready is high; each pixel passes
// through the walk register, then the address multiply-add into the output register.
// A step request while no line is active gives no pixel. Reset clears the
// active flag and the pipeline valid bits, and loads the frame registers.
// When the output stalls, the walk register holds and cmd_ready drops only
// once both registers are full. cfg_ready is always high.
`timescale 1ns / 1ps

module line_rasterizer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	output logic                                  cmd_ready,
	input  lr_pkg::lr_cmd_t                       cmd,
	output logic                                  pix_valid,
	input  logic                                  pix_ready,
	output lr_pkg::lr_pix_t                       pix,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [lr_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
	import lr_pkg::*;

	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int INC_BITS   = COORD_BITS + 2;
	localparam int DEC_BITS   = COORD_BITS + 3;
	localparam int YP_BITS    = COORD_BITS + PITCH_BITS + 1;
	localparam int X4_BITS    = COORD_BITS + 2;

	// Configuration registers.
	logic [FRAME_BITS-1:0] frame_width_q;
	logic [FRAME_BITS-1:0] frame_height_q;
	logic [PITCH_BITS-1:0] row_pitch_q;
	logic [BASE_BITS-1:0]  frame_base_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
			row_pitch_q    <= ROW_PITCH_RESET;
			frame_base_q   <= FRAME_BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FRAME_BITS-1:0];
				REG_ROW_PITCH:    row_pitch_q    <= cfg_data[PITCH_BITS-1:0];
				REG_FRAME_BASE:   frame_base_q   <= cfg_data[BASE_BITS-1:0];
			endcase
		end
	end

	// Line walk state.
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, major_end_q;
	logic signed [DEC_BITS-1:0]   decision_q, diagonal_q;
	logic [INC_BITS-1:0]          straight_q;
	logic                         x_major_q, minor_down_q, active_q;
	logic [COLOR_BITS-1:0]        color_q;

	// Pipeline registers.
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1;
	logic [COLOR_BITS-1:0]        color_s1;
	logic                         last_s1;
	logic                         pix_valid_q;
	lr_pix_t                      pix_q;

	logic out_free, s1_free, accept, is_start, produce;

	assign out_free  = !pix_valid_q || pix_ready;
	assign s1_free   = !valid_s1 || out_free;
	assign cmd_ready = s1_free;
	assign accept    = cmd_valid && cmd_ready;
	assign is_start  = (cmd.command == CMD_START);
	assign produce   = accept && (is_start || active_q);

	// Start decode.
	logic signed [DELTA_BITS-1:0] dx_s, dy_s;
	logic [DELTA_BITS-1:0]        dx_abs, dy_abs, maj_d, min_d;
	logic                         st_x_major, st_swap, st_minor_down, st_last;
	logic signed [COORD_BITS-1:0] near_x, near_y, far_x, far_y, st_major_end;
	logic signed [DEC_BITS-1:0]   st_decision, st_diagonal;
	logic [INC_BITS-1:0]          st_straight;

	always_comb begin
		dx_s = $signed({cmd.x_end[COORD_BITS-1], cmd.x_end})
			- $signed({cmd.x_start[COORD_BITS-1], cmd.x_start});
		dy_s = $signed({cmd.y_end[COORD_BITS-1], cmd.y_end})
			- $signed({cmd.y_start[COORD_BITS-1], cmd.y_start});
		dx_abs = dx_s[DELTA_BITS-1] ? DELTA_BITS'(-dx_s) : DELTA_BITS'(dx_s);
		dy_abs = dy_s[DELTA_BITS-1] ? DELTA_BITS'(-dy_s) : DELTA_BITS'(dy_s);
		// Ties between the axes go to x.
		st_x_major = (dy_abs <= dx_abs);
		maj_d = st_x_major ? dx_abs : dy_abs;
		min_d = st_x_major ? dy_abs : dx_abs;
		st_swap = st_x_major ? (cmd.x_start > cmd.x_end) : (cmd.y_start > cmd.y_end);
		near_x = st_swap ? cmd.x_end : cmd.x_start;
		near_y = st_swap ? cmd.y_end : cmd.y_start;
		far_x  = st_swap ? cmd.x_start : cmd.x_end;
		far_y  = st_swap ? cmd.y_start : cmd.y_end;
		st_major_end  = st_x_major ? far_x : far_y;
		st_minor_down = st_x_major ? (far_y < near_y) : (far_x < near_x);
		st_last       = st_x_major ? (near_x == far_x) : (near_y == far_y);
		st_decision = $signed(DEC_BITS'({min_d, 1'b0}) - DEC_BITS'(maj_d));
		st_straight = INC_BITS'({min_d, 1'b0});
		st_diagonal = $signed(DEC_BITS'({min_d, 1'b0}) - DEC_BITS'({maj_d, 1'b0}));
	end

	// One step of the walk.
	logic signed [COORD_BITS-1:0] maj_cur, min_cur, maj_next, min_next, step_x, step_y;
	logic signed [DEC_BITS-1:0]   step_decision;
	logic                         dec_neg, step_last;

	always_comb begin
		maj_cur  = x_major_q ? cur_x_q : cur_y_q;
		min_cur  = x_major_q ? cur_y_q : cur_x_q;
		dec_neg  = decision_q[DEC_BITS-1];
		maj_next = maj_cur + COORD_BITS'(1);
		if (dec_neg) begin
			min_next      = min_cur;
			step_decision = decision_q + $signed(DEC_BITS'(straight_q));
		end else begin
			min_next      = minor_down_q ? (min_cur - COORD_BITS'(1))
				: (min_cur + COORD_BITS'(1));
			step_decision = decision_q + diagonal_q;
		end
		step_x    = x_major_q ? maj_next : min_next;
		step_y    = x_major_q ? min_next : maj_next;
		step_last = (maj_next == major_end_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				active_q <= !st_last;
			end else if (active_q) begin
				active_q <= !step_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_start) begin
				cur_x_q      <= near_x;
				cur_y_q      <= near_y;
				major_end_q  <= st_major_end;
				decision_q   <= st_decision;
				straight_q   <= st_straight;
				diagonal_q   <= st_diagonal;
				x_major_q    <= st_x_major;
				minor_down_q <= st_minor_down;
				color_q      <= cmd.line_color;
			end else if (active_q) begin
				cur_x_q    <= step_x;
				cur_y_q    <= step_y;
				decision_q <= step_decision;
			end
		end
	end

	// Walk register: the pixel just produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			x_s1     <= is_start ? near_x : step_x;
			y_s1     <= is_start ? near_y : step_y;
			color_s1 <= is_start ? cmd.line_color : color_q;
			last_s1  <= is_start ? st_last : step_last;
		end
	end

	// Address and clip. The address wraps modulo the address width.
	logic signed [YP_BITS-1:0] y_pitch;
	logic signed [X4_BITS-1:0] x4;
	logic [ADDR_BITS-1:0]      address;
	logic                      in_frame;

	always_comb begin
		y_pitch = y_s1 * $signed({1'b0, row_pitch_q});
		x4      = {x_s1, 2'b00};
		address = ADDR_BITS'(frame_base_q)
			+ {{(ADDR_BITS-YP_BITS){y_pitch[YP_BITS-1]}}, y_pitch}
			+ {{(ADDR_BITS-X4_BITS){x4[X4_BITS-1]}}, x4};
		in_frame = !x_s1[COORD_BITS-1] && !y_s1[COORD_BITS-1]
			&& ($unsigned(x_s1) < frame_width_q)
			&& ($unsigned(y_s1) < frame_height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (out_free) begin
			pix_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			pix_q.pixel_x       <= x_s1;
			pix_q.pixel_y       <= y_s1;
			pix_q.pixel_address <= address;
			pix_q.pixel_value   <= color_s1;
			pix_q.visible       <= in_frame;
			pix_q.last          <= last_s1;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	// A step request with no active line must not create a pixel.
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_start && !active_q) |=> !valid_s1)
		else $error("step while idle produced a pixel");

	// A start request always produces its first pixel.
	a_start_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_start) |=> valid_s1)
		else $error("start request produced no pixel");

	// The held pixel is last exactly when the line has gone idle.
	a_last_active: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (last_s1 == !active_q))
		else $error("last flag and active state disagree");

	// Requests are refused only when both registers are full and stalled.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> (valid_s1 && pix_valid_q && !pix_ready))
		else $error("request refused without a full pipeline");

endmodule
